### rtl/ppp_pkg.sv
// Shared widths, types, register indexes and helpers for the pinhole point projection.
// No dependencies; every other file of the block imports this package.
package ppp_pkg;

  // field widths
  localparam int Q_W        = 16;  // quaternion component, Q1.14
  localparam int POS_W      = 20;  // position / point coordinate, Q12.8
  localparam int MAT_W      = 34;  // rotation matrix entry, Q28
  localparam int VEC_W      = 25;  // vector entering a transform, Q8
  localparam int FRAC_SHIFT = 28;  // Q36 to Q8
  localparam int BIAS_W     = POS_W + FRAC_SHIFT;
  localparam int PROD_W     = MAT_W + VEC_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int CRD_W      = 24;  // world / view coordinate, Q8
  localparam int FOC_W      = 24;  // focal length, Q16.8
  localparam int DIM_W      = 16;  // image dimension, pixels
  localparam int NUM_W      = 51;  // projection numerator, Q16
  localparam int DIVD_W     = 50;  // rounded numerator magnitude
  localparam int DIVS_W     = CRD_W - 1;  // positive depth
  localparam int PIX_W      = 32;  // pixel coordinate, Q24.8
  localparam int CENTER_SHIFT = 7; // width/2 in Q8 times depth in Q8
  localparam int DIV_STAGES = DIVD_W;
  localparam int CFG_W      = 64;
  localparam int IDX_W      = 3;
  localparam int LATENCY    = 63;

  localparam logic signed [MAT_W-1:0] ONE_Q28 = MAT_W'(1) <<< FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic [DIVD_W-1:0] PIX_POS_LIM = (DIVD_W'(1) << (PIX_W - 1)) - DIVD_W'(1);
  localparam logic [DIVD_W-1:0] PIX_NEG_LIM = DIVD_W'(1) << (PIX_W - 1);
  localparam logic [CFG_W-1:0]  ROT_RESET = CFG_W'(1) << 62;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CAM_ROT = 3'd0,
    REG_CAM_POS = 3'd1,
    REG_OBJ_ROT = 3'd2,
    REG_OBJ_POS = 3'd3,
    REG_FOCAL   = 3'd4,
    REG_IMAGE   = 3'd5
  } reg_idx_t;

  typedef logic signed [MAT_W-1:0]  mat_t  [0:2][0:2];
  typedef logic signed [VEC_W-1:0]  vec_t  [0:2];
  typedef logic signed [BIAS_W-1:0] bias_t [0:2];
  typedef logic signed [CRD_W-1:0]  crd_t  [0:2];

  // Q36 sum to Q8, round half up, saturate to coordinate width
  function automatic logic signed [CRD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    r = (acc + ROUND_HALF) >>> FRAC_SHIFT;
    if (r[ACC_W-1:CRD_W-1] == '0 || r[ACC_W-1:CRD_W-1] == '1) begin
      return r[CRD_W-1:0];
    end else if (r[ACC_W-1]) begin
      return {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CRD_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/ppp_rot_matrix.sv
// Rotation matrix from a packed Q1.14 quaternion, two register stages.
// Depends on ppp_pkg.
module ppp_rot_matrix import ppp_pkg::*; (
  input  logic             clk,
  input  logic [CFG_W-1:0] quat,
  output mat_t             mat
);

  logic signed [Q_W-1:0] qw, qx, qy, qz;
  logic signed [2*Q_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;

  assign qw = quat[4*Q_W-1:3*Q_W];
  assign qx = quat[3*Q_W-1:2*Q_W];
  assign qy = quat[2*Q_W-1:Q_W];
  assign qz = quat[Q_W-1:0];

  // component products
  always_ff @(posedge clk) begin
    pxx <= qx * qx;
    pyy <= qy * qy;
    pzz <= qz * qz;
    pxy <= qx * qy;
    pxz <= qx * qz;
    pyz <= qy * qz;
    pwx <= qw * qx;
    pwy <= qw * qy;
    pwz <= qw * qz;
  end

  // matrix entries, unnormalized
  always_ff @(posedge clk) begin
    mat[0][0] <= ONE_Q28 - ((MAT_W'(pyy) + MAT_W'(pzz)) <<< 1);
    mat[0][1] <= (MAT_W'(pxy) - MAT_W'(pwz)) <<< 1;
    mat[0][2] <= (MAT_W'(pxz) + MAT_W'(pwy)) <<< 1;
    mat[1][0] <= (MAT_W'(pxy) + MAT_W'(pwz)) <<< 1;
    mat[1][1] <= ONE_Q28 - ((MAT_W'(pxx) + MAT_W'(pzz)) <<< 1);
    mat[1][2] <= (MAT_W'(pyz) - MAT_W'(pwx)) <<< 1;
    mat[2][0] <= (MAT_W'(pxz) - MAT_W'(pwy)) <<< 1;
    mat[2][1] <= (MAT_W'(pyz) + MAT_W'(pwx)) <<< 1;
    mat[2][2] <= ONE_Q28 - ((MAT_W'(pxx) + MAT_W'(pyy)) <<< 1);
  end

endmodule

### rtl/ppp_mat_vec.sv
// Pipelined 3x3 matrix times vector plus bias, rounded and saturated to Q8.
// Depends on ppp_pkg; three register stages.
module ppp_mat_vec import ppp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  vec_t vec,
  input  mat_t mat,
  input  bias_t bias,
  output logic out_valid,
  output crd_t res
);

  logic signed [PROD_W-1:0] prod [0:2][0:2];
  logic signed [BIAS_W-1:0] bias_q [0:2];
  logic signed [ACC_W-1:0]  acc [0:2];
  logic v1, v2;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // products, sums, rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= PROD_W'(mat[i][j]) * PROD_W'(vec[j]);
      end
      bias_q[i] <= bias[i];
      acc[i] <= ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2])
              + ACC_W'(bias_q[i]);
      res[i] <= round_sat(acc[i]);
    end
  end

endmodule

### rtl/ppp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, positive divisor.
// Depends on ppp_pkg.
module ppp_divider import ppp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  input  logic              in_neg,
  output logic              out_valid,
  output logic [DIVD_W-1:0] quotient,
  output logic              out_neg
);

  logic              vld [0:DIV_STAGES-1];
  logic [DIVS_W-1:0] rem [0:DIV_STAGES-1];
  logic [DIVD_W-1:0] num [0:DIV_STAGES-1];
  logic [DIVD_W-1:0] quo [0:DIV_STAGES-1];
  logic [DIVS_W-1:0] den [0:DIV_STAGES-1];
  logic              neg [0:DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic              c_vld, c_neg, ge;
    logic [DIVS_W-1:0] c_rem, c_den;
    logic [DIVD_W-1:0] c_num, c_quo;
    logic [DIVS_W:0]   trial;

    if (g == 0) begin : g_first
      assign c_vld = in_valid;
      assign c_rem = '0;
      assign c_num = dividend;
      assign c_quo = '0;
      assign c_den = divisor;
      assign c_neg = in_neg;
    end else begin : g_next
      assign c_vld = vld[g-1];
      assign c_rem = rem[g-1];
      assign c_num = num[g-1];
      assign c_quo = quo[g-1];
      assign c_den = den[g-1];
      assign c_neg = neg[g-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {c_rem, c_num[DIVD_W-1]};
    assign ge = trial >= {1'b0, c_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[g] <= ge ? DIVS_W'(trial - {1'b0, c_den}) : trial[DIVS_W-1:0];
      num[g] <= c_num << 1;
      quo[g] <= {c_quo[DIVD_W-2:0], ge};
      den[g] <= c_den;
      neg[g] <= c_neg;
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = quo[DIV_STAGES-1];
  assign out_neg   = neg[DIV_STAGES-1];

endmodule

### rtl/pinhole_point_projection.sv
// Pinhole point projection, top level.
// Depends on ppp_pkg, ppp_rot_matrix, ppp_mat_vec and ppp_divider.
//
// Usage:
//   A point (point_x, point_y, point_z) transfers at a rising edge with start
//   high and busy low. busy is low whenever rst is low, so one point can
//   transfer every cycle. Each point yields exactly one result, shown on
//   pixel_u, pixel_v, depth and behind_camera for one cycle with done high,
//   after the input, transform, numerator, divider and output registers;
//   results leave in arrival order. The receiver takes every result; there
//   is no stall.
//   Throughput is one point per cycle, set by the fully pipelined datapath:
//   two matrix-vector transforms of three stages each and a restoring
//   divider of one quotient bit per stage (50 stages) for u and v.
// Configuration:
//   cfg_write with cfg_index and cfg_data writes a register at the edge; an
//   index past the last register is ignored. Writes are made while no point
//   is in flight; the rotation matrices follow a write through ppp_rot_matrix.
// Reset:
//   rst (synchronous) empties the pipeline and restores identity rotations,
//   zero positions, focal lengths and image size. busy is high during reset.
module pinhole_point_projection import ppp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  point_x,
  input  logic signed [POS_W-1:0]  point_y,
  input  logic signed [POS_W-1:0]  point_z,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     done,
  output logic signed [PIX_W-1:0]  pixel_u,
  output logic signed [PIX_W-1:0]  pixel_v,
  output logic signed [CRD_W-1:0]  depth,
  output logic                     behind_camera
);

  // configuration registers
  logic [CFG_W-1:0]     camera_rotation, object_rotation;
  logic [3*POS_W-1:0]   camera_position, object_position;
  logic [2*FOC_W-1:0]   focal_lengths;
  logic [2*DIM_W-1:0]   image_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_rotation <= ROT_RESET;
      object_rotation <= ROT_RESET;
      camera_position <= '0;
      object_position <= '0;
      focal_lengths   <= '0;
      image_size      <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAM_ROT: camera_rotation <= cfg_data;
        REG_CAM_POS: camera_position <= cfg_data[3*POS_W-1:0];
        REG_OBJ_ROT: object_rotation <= cfg_data;
        REG_OBJ_POS: object_position <= cfg_data[3*POS_W-1:0];
        REG_FOCAL:   focal_lengths   <= cfg_data[2*FOC_W-1:0];
        REG_IMAGE:   image_size      <= cfg_data[2*DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // rotation matrices
  mat_t obj_mat, cam_mat, cam_mat_t;

  ppp_rot_matrix u_obj_rot (.clk(clk), .quat(object_rotation), .mat(obj_mat));
  ppp_rot_matrix u_cam_rot (.clk(clk), .quat(camera_rotation), .mat(cam_mat));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cam_mat_t[i][j] = cam_mat[j][i];
      end
    end
  end

  // input stages, lined up with the matrix registers
  logic in_vld [0:2];
  vec_t in_pt [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 3; s++) in_vld[s] <= 1'b0;
    end else begin
      in_vld[0] <= start && !busy;
      for (int s = 1; s < 3; s++) in_vld[s] <= in_vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    in_pt[0][0] <= VEC_W'(point_x);
    in_pt[0][1] <= VEC_W'(point_y);
    in_pt[0][2] <= VEC_W'(point_z);
    for (int s = 1; s < 3; s++) in_pt[s] <= in_pt[s-1];
  end

  // object pose into world coordinates
  bias_t obj_bias, zero_bias;
  crd_t  world;
  logic  world_vld;

  assign obj_bias[0] = {object_position[3*POS_W-1:2*POS_W], {FRAC_SHIFT{1'b0}}};
  assign obj_bias[1] = {object_position[2*POS_W-1:POS_W], {FRAC_SHIFT{1'b0}}};
  assign obj_bias[2] = {object_position[POS_W-1:0], {FRAC_SHIFT{1'b0}}};
  assign zero_bias[0] = '0;
  assign zero_bias[1] = '0;
  assign zero_bias[2] = '0;

  ppp_mat_vec u_obj_xform (
    .clk(clk), .rst(rst), .in_valid(in_vld[2]), .vec(in_pt[2]),
    .mat(obj_mat), .bias(obj_bias), .out_valid(world_vld), .res(world)
  );

  // subtract the camera position
  logic signed [POS_W-1:0] cam_pos [0:2];
  vec_t rel;
  logic rel_vld;

  assign cam_pos[0] = camera_position[3*POS_W-1:2*POS_W];
  assign cam_pos[1] = camera_position[2*POS_W-1:POS_W];
  assign cam_pos[2] = camera_position[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_vld <= 1'b0;
    end else begin
      rel_vld <= world_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rel[i] <= VEC_W'(world[i]) - VEC_W'(cam_pos[i]);
    end
  end

  // transposed camera rotation into view coordinates
  crd_t view;
  logic view_vld;

  ppp_mat_vec u_cam_xform (
    .clk(clk), .rst(rst), .in_valid(rel_vld), .vec(rel),
    .mat(cam_mat_t), .bias(zero_bias), .out_valid(view_vld), .res(view)
  );

  // intrinsics: focal products and principal point terms
  logic signed [VEC_W-1:0] up;
  logic signed [NUM_W-1:0] pu, pv, cu, cv;
  logic signed [CRD_W-1:0] n1_depth;
  logic                    n1_behind, n1_vld;

  assign up = -VEC_W'(view[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_vld <= 1'b0;
    end else begin
      n1_vld <= view_vld;
    end
  end

  always_ff @(posedge clk) begin
    pu <= NUM_W'($signed({1'b0, focal_lengths[2*FOC_W-1:FOC_W]})) * NUM_W'(view[1]);
    pv <= NUM_W'($signed({1'b0, focal_lengths[FOC_W-1:0]})) * NUM_W'(up);
    cu <= NUM_W'($signed({1'b0, image_size[2*DIM_W-1:DIM_W]})) * NUM_W'(view[0]);
    cv <= NUM_W'($signed({1'b0, image_size[DIM_W-1:0]})) * NUM_W'(view[0]);
    n1_depth  <= view[0];
    n1_behind <= view[0] <= 0;
  end

  // numerators, magnitude plus half the divisor for rounding
  logic signed [NUM_W-1:0] nu, nv;
  logic [NUM_W-1:0]        mag_u, mag_v;
  logic [DIVD_W-1:0]       n2_u, n2_v;
  logic [DIVS_W-1:0]       n2_den;
  logic                    n2_neg_u, n2_neg_v, n2_vld;
  logic signed [CRD_W-1:0] n2_depth;
  logic                    n2_behind;

  always_comb begin
    nu = pu + (cu <<< CENTER_SHIFT);
    nv = pv + (cv <<< CENTER_SHIFT);
    mag_u = nu[NUM_W-1] ? NUM_W'(-nu) : NUM_W'(nu);
    mag_v = nv[NUM_W-1] ? NUM_W'(-nv) : NUM_W'(nv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_vld <= 1'b0;
    end else begin
      n2_vld <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    n2_u <= DIVD_W'(mag_u + NUM_W'(n1_depth[CRD_W-1:1]));
    n2_v <= DIVD_W'(mag_v + NUM_W'(n1_depth[CRD_W-1:1]));
    n2_neg_u <= nu[NUM_W-1];
    n2_neg_v <= nv[NUM_W-1];
    n2_den <= n1_behind ? DIVS_W'(1) : n1_depth[DIVS_W-1:0];
    n2_depth <= n1_depth;
    n2_behind <= n1_behind;
  end

  // divide by depth
  logic [DIVD_W-1:0] q_u, q_v;
  logic              qn_u, qn_v, q_vld, q_vld_v;

  ppp_divider u_div_u (
    .clk(clk), .rst(rst), .in_valid(n2_vld), .dividend(n2_u), .divisor(n2_den),
    .in_neg(n2_neg_u), .out_valid(q_vld), .quotient(q_u), .out_neg(qn_u)
  );

  ppp_divider u_div_v (
    .clk(clk), .rst(rst), .in_valid(n2_vld), .dividend(n2_v), .divisor(n2_den),
    .in_neg(n2_neg_v), .out_valid(q_vld_v), .quotient(q_v), .out_neg(qn_v)
  );

  // depth and flag ride alongside the dividers
  logic signed [CRD_W-1:0] side_depth  [0:DIV_STAGES-1];
  logic                    side_behind [0:DIV_STAGES-1];

  always_ff @(posedge clk) begin
    side_depth[0]  <= n2_depth;
    side_behind[0] <= n2_behind;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_depth[s]  <= side_depth[s-1];
      side_behind[s] <= side_behind[s-1];
    end
  end

  // sign, saturate and register the result
  function automatic logic signed [PIX_W-1:0] to_pixel(input logic [DIVD_W-1:0] q,
                                                       input logic neg);
    if (neg) begin
      return (q > PIX_NEG_LIM) ? {1'b1, {(PIX_W-1){1'b0}}} : PIX_W'(-q);
    end else begin
      return (q > PIX_POS_LIM) ? {1'b0, {(PIX_W-1){1'b1}}} : PIX_W'(q);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    pixel_u <= side_behind[DIV_STAGES-1] ? '0 : to_pixel(q_u, qn_u);
    pixel_v <= side_behind[DIV_STAGES-1] ? '0 : to_pixel(q_v, qn_v);
    depth <= side_depth[DIV_STAGES-1];
    behind_camera <= side_behind[DIV_STAGES-1];
  end

  // checks
  a_div_aligned: assert property (@(posedge clk) disable iff (rst) q_vld == q_vld_v)
    else $error("divider valid bits out of step");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a point transfer at the expected latency");
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    done && behind_camera |-> pixel_u == 0 && pixel_v == 0)
    else $error("pixels not zero behind the camera");
  a_front_depth: assert property (@(posedge clk) disable iff (rst)
    done && !behind_camera |-> depth > 0)
    else $error("flag disagrees with depth");

endmodule

### sim/tb.sv
// Self-checking testbench for pinhole_point_projection.
// Depends on ppp_pkg and the block's RTL; a scoreboard class predicts each projection.
`timescale 1ns / 100ps

module tb;
  import ppp_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int MAX_GAP = 12;

  typedef struct {
    logic signed [PIX_W-1:0] u;
    logic signed [PIX_W-1:0] v;
    logic signed [CRD_W-1:0] dep;
    logic                    behind;
  } projection_t;

  // projection predictor and store of expected pixels
  class projection_scoreboard;
    logic [63:0] cam_rot, cam_pos, obj_rot, obj_pos, focal, img;
    projection_t pending_pixels[$];
    int mismatches;

    function new();
      cam_rot = ROT_RESET;
      obj_rot = ROT_RESET;
      cam_pos = '0;
      obj_pos = '0;
      focal = '0;
      img = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_CAM_ROT: cam_rot = data;
        REG_CAM_POS: cam_pos = data & ((64'd1 << 60) - 1);
        REG_OBJ_ROT: obj_rot = data;
        REG_OBJ_POS: obj_pos = data & ((64'd1 << 60) - 1);
        REG_FOCAL:   focal = data & ((64'd1 << 48) - 1);
        REG_IMAGE:   img = data & 64'hFFFF_FFFF;
        default: ;
      endcase
    endfunction

    function longint sat(longint x, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    // q36 to q8, round half up, saturate to 24 bits
    function longint to_q8(longint acc);
      return sat((acc + (longint'(1) <<< 27)) >>> 28, 24);
    endfunction

    // rotation matrix entry in q28 from a packed quaternion
    function longint rot_entry(logic [63:0] q, int i, int j);
      longint w, x, y, z, one;
      w = longint'($signed(q[63:48]));
      x = longint'($signed(q[47:32]));
      y = longint'($signed(q[31:16]));
      z = longint'($signed(q[15:0]));
      one = longint'(1) <<< 28;
      case (i * 3 + j)
        0: return one - 2 * (y * y + z * z);
        1: return 2 * (x * y - w * z);
        2: return 2 * (x * z + w * y);
        3: return 2 * (x * y + w * z);
        4: return one - 2 * (x * x + z * z);
        5: return 2 * (y * z - w * x);
        6: return 2 * (x * z - w * y);
        7: return 2 * (y * z + w * x);
        default: return one - 2 * (x * x + y * y);
      endcase
    endfunction

    function longint pos_field(logic [63:0] p, int i);
      logic [19:0] f;
      f = p[59 - 20 * i -: 20];
      return longint'($signed(f));
    endfunction

    function longint div_nearest(longint n, longint d);
      longint a, q;
      a = n < 0 ? -n : n;
      q = (a + d / 2) / d;
      return n < 0 ? -q : q;
    endfunction

    // note a transferred point and queue its projection
    function void note_point(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                             logic signed [POS_W-1:0] pz);
      longint pt[3], wrl[3], dif[3], vw[3], acc, fx, fy, wd, ht;
      projection_t e;
      pt[0] = longint'(px);
      pt[1] = longint'(py);
      pt[2] = longint'(pz);
      for (int i = 0; i < 3; i++) begin
        acc = pos_field(obj_pos, i) <<< 28;
        for (int j = 0; j < 3; j++) acc += rot_entry(obj_rot, i, j) * pt[j];
        wrl[i] = to_q8(acc);
        dif[i] = wrl[i] - pos_field(cam_pos, i);
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += rot_entry(cam_rot, j, i) * dif[j];
        vw[i] = to_q8(acc);
      end
      e.dep = CRD_W'(vw[0]);
      e.behind = vw[0] <= 0;
      e.u = '0;
      e.v = '0;
      if (!e.behind) begin
        fx = longint'(focal[47:24]);
        fy = longint'(focal[23:0]);
        wd = longint'(img[31:16]);
        ht = longint'(img[15:0]);
        e.u = PIX_W'(sat(div_nearest(fx * vw[1] + wd * 128 * vw[0], vw[0]), 32));
        e.v = PIX_W'(sat(div_nearest(fy * (-vw[2]) + ht * 128 * vw[0], vw[0]), 32));
      end
      pending_pixels.push_back(e);
    endfunction

    function void check_pixel(projection_t got);
      projection_t e;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result u=%0d v=%0d", got.u, got.v);
        return;
      end
      e = pending_pixels.pop_front();
      if (got.u !== e.u || got.v !== e.v || got.dep !== e.dep || got.behind !== e.behind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp u=%0d v=%0d d=%0d b=%0b, got u=%0d v=%0d d=%0d b=%0b",
                   e.u, e.v, e.dep, e.behind, got.u, got.v, got.dep, got.behind);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done, behind_camera;
  logic signed [PIX_W-1:0] pixel_u, pixel_v;
  logic signed [CRD_W-1:0] depth;

  projection_scoreboard sb = new();
  bit no_gaps;

  pinhole_point_projection uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    projection_t got;
    if (!rst && done) begin
      got.u = pixel_u;
      got.v = pixel_v;
      got.dep = depth;
      got.behind = behind_camera;
      sb.check_pixel(got);
    end
  end

  // run limit
  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

  // one point transfer, after a random gap unless no_gaps is set
  task automatic send_point(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    point_x = x;
    point_y = y;
    point_z = z;
    do @(posedge clk); while (busy);
    sb.note_point(x, y, z);
    @(negedge clk);
  endtask

  // let the pipeline empty before touching registers
  task automatic drain();
    start = 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // quaternion near identity, or fully random
  function automatic logic [63:0] pick_quat();
    logic [15:0] w, x, y, z;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    w = 16'(16384 - $urandom_range(0, 3000));
    x = 16'($signed($urandom_range(0, 12000)) - 6000);
    y = 16'($signed($urandom_range(0, 12000)) - 6000);
    z = 16'($signed($urandom_range(0, 12000)) - 6000);
    return {w, x, y, z};
  endfunction

  function automatic logic [59:0] pick_pos();
    logic [19:0] f[3];
    for (int i = 0; i < 3; i++)
      f[i] = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($signed($urandom_range(0, 8192)) - 4096);
    return {f[0], f[1], f[2]};
  endfunction

  function automatic logic signed [POS_W-1:0] pick_coord();
    return ($urandom_range(0, 2) == 0) ? POS_W'($urandom)
                                       : POS_W'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  task automatic random_points(int n);
    logic signed [POS_W-1:0] x;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      x = pick_coord();
      // mostly in front of the camera
      if ($urandom_range(0, 3) != 0 && x < 0) x = -x;
      send_point(x, pick_coord(), pick_coord());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    no_gaps = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: reset registers, extremes, zero and negative depth
    send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_point(20'sh80000, 20'sh80000, 20'sh80000);
    send_point('0, '0, '0);
    drain();
    write_reg(REG_FOCAL, 64'({24'd128000, 24'd102400}));
    write_reg(REG_IMAGE, 64'({16'd640, 16'd480}));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    repeat (3) @(negedge clk);
    send_point(20'sd256, 20'sd0, 20'sd0);
    send_point(20'sd256, 20'sd128, -20'sd128);
    send_point(20'sd0, 20'sd50, 20'sd50);
    send_point(-20'sd1, 20'sd50, 20'sd50);
    send_point(20'sd1, 20'sh7FFFF, 20'sh80000);
    send_point(20'sd1, 20'sh80000, 20'sh7FFFF);
    send_point(20'sh7FFFF, 20'sh80000, 20'sh80000);
    send_point(20'sh80000, 20'sd3, 20'sd3);
    drain();

    // extremes of every register, including a non-unit quaternion
    write_reg(REG_CAM_ROT, '1);
    write_reg(REG_CAM_POS, '1);
    write_reg(REG_OBJ_ROT, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_OBJ_POS, 64'({20'h7FFFF, 20'h80000, 20'h7FFFF}));
    write_reg(REG_FOCAL, '1);
    write_reg(REG_IMAGE, '1);
    repeat (3) @(negedge clk);
    send_point(20'sd1, 20'sd1, 20'sd1);
    send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh80000);
    random_points(40);
    drain();

    // random settings, several phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAM_ROT, (ph == 0) ? ROT_RESET : pick_quat());
      write_reg(REG_CAM_POS, (ph == 0) ? 64'd0 : 64'(pick_pos()));
      write_reg(REG_OBJ_ROT, pick_quat());
      write_reg(REG_OBJ_POS, 64'(pick_pos()));
      write_reg(REG_FOCAL, (ph == 7) ? 64'd0 : {$urandom, $urandom});
      write_reg(REG_IMAGE, (ph == 7) ? 64'd0 : 64'($urandom));
      repeat (3) @(negedge clk);
      random_points(80);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
